// ===== rtl/core/kcs_pkg.sv =====
// kcs_pkg: shared types and constants for the k-combination successor.
// Field widths, request and register codes, sequencer states.
// No dependencies.
package kcs_pkg;

    localparam int DEF_MAX_K   = 16;
    localparam int DEF_MAX_SET = 64;

    localparam int REQ_W     = 2;
    localparam int POS_W     = 4;
    localparam int VAL_W     = 7;
    localparam int SET_W     = 7;
    localparam int SUB_W     = 5;
    localparam int OIDX_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;
    localparam int CEIL_W    = VAL_W + 2;

    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE = 1'b1;

    localparam logic [SET_W-1:0] SET_SIZE_RST    = 7'd8;
    localparam logic [SUB_W-1:0] SUBSET_SIZE_RST = 5'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_INIT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EXH
    } state_t;

endpackage

// ===== rtl/core/kcs_ram.sv =====
// kcs_ram: element store, one write port and one registered read port.
// Depends on kcs_pkg for default widths.
module kcs_ram
    import kcs_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_K,
    parameter int AW    = 4
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [VAL_W-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [VAL_W-1:0] rd_data
);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/k_combination_successor.sv =====
// Sequence: a write is stored directly; a restart fills the k slots, then emits them; an
// advance scans slots from the right for the pivot (i = pivot slot), refills slots i+1
// to k-1, then emits all k elements; if no pivot is found it reports exhausted.
// Requests: one request at a time, the next is taken once the final result is
// loaded; emission waits while the output is held.
// Reset (async, active low): idle, no output pending, set_size 8, subset_size 4.
module k_combination_successor
    import kcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [POS_W-1:0]     position,
    input  logic [VAL_W-1:0]     value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OIDX_W-1:0]    elem_index,
    output logic [VAL_W-1:0]     elem_value,
    output logic                 found,
    output logic                 last
);

    // sizes are tied to the fixed field widths
    localparam int MAX_K   = DEF_MAX_K;
    localparam int MAX_SET = DEF_MAX_SET;

    localparam int IW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KCW0  = $clog2(MAX_K + 1);
    localparam int KCW   = (KCW0 > SUB_W) ? KCW0 : SUB_W;
    localparam int NCW0  = $clog2(MAX_SET + 1);
    localparam int NCW   = (NCW0 > SET_W) ? NCW0 : SET_W;
    localparam int PCW   = (KCW0 > POS_W) ? KCW0 : POS_W;

    state_t state_reg, state_next;

    logic [SET_W-1:0]        set_size_reg;
    logic [SUB_W-1:0]        subset_size_reg;
    logic [IW-1:0]           idx_reg;
    logic [IW-1:0]           kl_reg;
    logic signed [CEIL_W-1:0] ceil_reg;
    logic [VAL_W-1:0]        run_reg;

    logic                    out_valid_reg;
    logic [OIDX_W-1:0]       elem_index_reg;
    logic [VAL_W-1:0]        elem_value_reg;
    logic                    found_reg;
    logic                    last_reg;

    // effective k and n from the configuration
    logic [KCW-1:0]   sub_ext, k_eff;
    logic [NCW-1:0]   set_ext, n_eff;
    logic [IW-1:0]    kl_w;
    logic [VAL_W-1:0] n_val;

    always_comb
    begin
        sub_ext = KCW'(subset_size_reg);
        if (sub_ext == '0)
            k_eff = KCW'(1);
        else if (sub_ext > KCW'(MAX_K))
            k_eff = KCW'(MAX_K);
        else
            k_eff = sub_ext;
        kl_w = IW'(k_eff - KCW'(1));

        set_ext = NCW'(set_size_reg);
        if (set_ext == '0)
            n_eff = NCW'(1);
        else if (set_ext > NCW'(MAX_SET))
            n_eff = NCW'(MAX_SET);
        else
            n_eff = set_ext;
        n_val = VAL_W'(n_eff);
    end

    logic             accept;
    logic             out_free;
    logic             at_last;
    logic [VAL_W-1:0] rd_data;
    logic             hit;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign at_last  = (idx_reg == kl_reg);
    assign hit      = $signed({2'b00, rd_data}) < ceil_reg;

    // shared incrementer
    logic [VAL_W-1:0] inc_in, inc_out;
    assign inc_out = inc_in + VAL_W'(1);

    // store port controls
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [IW-1:0]    rd_addr;
    logic             out_load;
    logic             out_exh;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_ADVANCE)
                        state_next = ST_SCAN;
                    else if (req_type == REQ_RESTART)
                        state_next = ST_INIT;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                    state_next = at_last ? ST_EMIT_RD : ST_FILL;
                else if (idx_reg == '0)
                    state_next = ST_EXH;
            end
            ST_FILL, ST_INIT:
            begin
                if (at_last)
                    state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
                state_next = ST_EMIT_LD;
            ST_EMIT_LD:
            begin
                if (out_free && at_last)
                    state_next = ST_IDLE;
            end
            ST_EXH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_data  = inc_out;
        rd_addr  = idx_reg;
        inc_in   = run_reg;
        out_load = 1'b0;
        out_exh  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                wr_en    = in_valid && (req_type == REQ_WRITE)
                           && (PCW'(position) < PCW'(MAX_K));
                wr_addr  = IW'(position);
                wr_data  = value;
                // prefetch the rightmost slot for a scan
                rd_addr  = kl_w;
            end
            ST_SCAN:
            begin
                inc_in  = rd_data;
                wr_en   = hit;
                rd_addr = idx_reg - IW'(1);
            end
            ST_FILL:
            begin
                inc_in = run_reg;
                wr_en  = 1'b1;
            end
            ST_INIT:
            begin
                inc_in = VAL_W'(idx_reg);
                wr_en  = 1'b1;
            end
            ST_EMIT_RD:
                rd_addr = idx_reg;
            ST_EMIT_LD:
            begin
                out_load = out_free;
                rd_addr  = out_free ? idx_reg + IW'(1) : idx_reg;
            end
            ST_EXH:
                out_exh = out_free;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    kcs_ram #(
        .DEPTH (MAX_K),
        .AW    (IW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg    <= SET_SIZE_RST;
            subset_size_reg <= SUBSET_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SET_SIZE:    set_size_reg    <= cfg_data[SET_W-1:0];
                CFG_SUBSET_SIZE: subset_size_reg <= cfg_data[SUB_W-1:0];
                default:         set_size_reg    <= set_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kl_reg   <= kl_w;
                    ceil_reg <= $signed({2'b00, n_val});
                    idx_reg  <= (req_type == REQ_ADVANCE) ? kl_w : '0;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    run_reg <= inc_out;
                    idx_reg <= at_last ? '0 : idx_reg + IW'(1);
                end
                else
                begin
                    // ceiling drops by one per slot going left
                    idx_reg  <= idx_reg - IW'(1);
                    ceil_reg <= ceil_reg - CEIL_W'(1);
                end
            end
            ST_FILL, ST_INIT:
            begin
                run_reg <= inc_out;
                idx_reg <= at_last ? '0 : idx_reg + IW'(1);
            end
            ST_EMIT_LD:
            begin
                if (out_free)
                    idx_reg <= idx_reg + IW'(1);
            end
            default:
            begin
                run_reg <= run_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load || out_exh)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            elem_index_reg <= OIDX_W'(idx_reg);
            elem_value_reg <= rd_data;
            found_reg      <= 1'b1;
            last_reg       <= at_last;
        end
        else if (out_exh)
        begin
            elem_index_reg <= '0;
            elem_value_reg <= '0;
            found_reg      <= 1'b0;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign elem_index = elem_index_reg;
    assign elem_value = elem_value_reg;
    assign found      = found_reg;
    assign last       = last_reg;

endmodule

// ===== verif/tb_k_combination_successor.sv =====
// Testbench for k_combination_successor: directed and random request traffic
// checked against an in-bench model of the lexicographic next-combination rule.
// Depends on kcs_pkg and the k_combination_successor RTL.
module tb_k_combination_successor;
    import kcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

    localparam int QUIET_CYCLES   = 2 * DEF_MAX_K + 8;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_TARGET    = 280;
    localparam int MAX_REPORTS    = 100;

    typedef struct packed {
        logic [OIDX_W-1:0] slot;
        logic [VAL_W-1:0]  elem;
        logic              found;
        logic              last;
    } elem_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SET_SIZE;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [REQ_W-1:0]     req_type = REQ_WRITE;
    logic [POS_W-1:0]     position = '0;
    logic [VAL_W-1:0]     value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [OIDX_W-1:0]    elem_index;
    logic [VAL_W-1:0]     elem_value;
    logic                 found;
    logic                 last;

    // model of the block's store and registers
    logic [VAL_W-1:0] combo_shadow [DEF_MAX_K];
    bit               slot_loaded  [DEF_MAX_K];
    logic [SET_W-1:0] n_shadow = SET_SIZE_RST;
    logic [SUB_W-1:0] k_shadow = SUBSET_SIZE_RST;

    elem_result_t pending_elems [$];
    elem_result_t head_elem;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    bit sink_hold    = 1'b0;

    int error_cnt    = 0;
    int item_cnt     = 0;
    int result_cnt   = 0;
    int exhaust_cnt  = 0;
    int setting_cnt  = 0;
    int stall_cycles = 0;

    k_combination_successor DUT (.*);

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int active_k();
        int k;
        k = int'(k_shadow);
        if (k == 0) k = 1;
        if (k > DEF_MAX_K) k = DEF_MAX_K;
        return k;
    endfunction

    function automatic int active_n();
        int n;
        n = int'(n_shadow);
        if (n == 0) n = 1;
        if (n > DEF_MAX_SET) n = DEF_MAX_SET;
        return n;
    endfunction

    // an advance reads slots 0..k-1; all of them must hold a written value
    function automatic bit advance_ready();
        bit ok;
        ok = 1'b1;
        for (int i = 0; i < active_k(); i++)
            if (!slot_loaded[i]) ok = 1'b0;
        return ok;
    endfunction

    task automatic push_combination(input int k);
        elem_result_t e;
        for (int i = 0; i < k; i++) begin
            e.slot  = OIDX_W'(i);
            e.elem  = combo_shadow[i];
            e.found = 1'b1;
            e.last  = (i == k - 1);
            pending_elems = {pending_elems, e};
        end
    endtask

    task automatic predict_request(input logic [REQ_W-1:0] rq, input logic [POS_W-1:0] pos,
                                   input logic [VAL_W-1:0] val);
        int k, n, pivot;
        elem_result_t e;
        k = active_k();
        n = active_n();
        pivot = -1;
        case (rq)
            REQ_WRITE: begin
                combo_shadow[pos] = val;
                slot_loaded[pos]  = 1'b1;
            end
            REQ_RESTART: begin
                for (int i = 0; i < k; i++) begin
                    combo_shadow[i] = VAL_W'(i + 1);
                    slot_loaded[i]  = 1'b1;
                end
                push_combination(k);
            end
            REQ_ADVANCE: begin
                // rightmost slot still below its ceiling; ceilings may go negative
                for (int i = k - 1; i >= 0 && pivot < 0; i--)
                    if (int'(combo_shadow[i]) < n - k + i + 1) pivot = i;
                if (pivot >= 0) begin
                    combo_shadow[pivot] = combo_shadow[pivot] + 1'b1;
                    for (int j = pivot + 1; j < k; j++)
                        combo_shadow[j] = combo_shadow[j-1] + 1'b1;
                    push_combination(k);
                end else begin
                    e = '{slot: '0, elem: '0, found: 1'b0, last: 1'b1};
                    pending_elems = {pending_elems, e};
                    exhaust_cnt++;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_req(input logic [REQ_W-1:0] rq, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val);
        if (src_idle_en && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 18);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        position <= pos;
        value    <= val;
        do @(posedge clk); while (!in_ready);
        predict_request(rq, pos, val);
        if (rq != REQ_RESERVED) item_cnt++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_elems.size() != 0);
    endtask

    // a write gives no result, so let any trailing work finish as well
    task automatic wait_quiet();
        wait_drain();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] n_data, input logic [CFG_W-1:0] k_data);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SET_SIZE;
        cfg_data  <= n_data;
        @(posedge clk);
        n_shadow  = SET_W'(n_data);
        cfg_index <= CFG_SUBSET_SIZE;
        cfg_data  <= k_data;
        @(posedge clk);
        k_shadow  = SUB_W'(k_data);
        cfg_we    <= 1'b0;
        setting_cnt++;
    endtask

    task automatic advance_or_restart();
        if (advance_ready())
            send_req(REQ_ADVANCE, POS_W'($urandom), VAL_W'($urandom));
        else
            send_req(REQ_RESTART, POS_W'($urandom), VAL_W'($urandom));
    endtask

    // writes an ascending, in-range combination slot by slot
    task automatic load_random_combination();
        int k, n, lo;
        logic [VAL_W-1:0] v;
        k  = active_k();
        n  = active_n();
        lo = 1;
        for (int i = 0; i < k; i++) begin
            v = VAL_W'($urandom_range(n - k + i + 1, lo));
            send_req(REQ_WRITE, POS_W'(i), v);
            lo = int'(v) + 1;
        end
    endtask

    task automatic test_defaults();
        send_req(REQ_RESTART, '0, '0);
        send_req(REQ_ADVANCE, '0, '0);
        send_req(REQ_ADVANCE, '1, '1);
        // last combination of 4 from 8, then exhaustion twice
        for (int i = 0; i < 4; i++)
            send_req(REQ_WRITE, POS_W'(i), VAL_W'(5 + i));
        send_req(REQ_ADVANCE, '0, '0);
        send_req(REQ_ADVANCE, '0, '0);
        send_req(REQ_WRITE, POS_W'(3), VAL_W'(7));
        send_req(REQ_ADVANCE, '0, '0);
        send_req(REQ_WRITE, POS_W'(0), VAL_W'(0));
        send_req(REQ_ADVANCE, '0, '0);
        send_req(REQ_RESERVED, '1, '1);
        send_req(REQ_WRITE, '1, '1);
        // value above the ceiling is stored unchecked
        send_req(REQ_WRITE, POS_W'(3), VAL_W'(64));
        send_req(REQ_ADVANCE, '0, '0);
    endtask

    task automatic test_config_extremes();
        set_config('0, '0);                  // both read as one
        send_req(REQ_RESTART, '0, '0);
        send_req(REQ_ADVANCE, '0, '0);
        set_config('1, '1);                  // both saturate
        send_req(REQ_RESTART, '0, '0);
        send_req(REQ_ADVANCE, '0, '0);
        set_config(CFG_W'(64), CFG_W'(1));
        send_req(REQ_WRITE, '0, VAL_W'(63));
        send_req(REQ_ADVANCE, '0, '0);
        send_req(REQ_ADVANCE, '0, '0);
        set_config(CFG_W'(5), CFG_W'(9));   // subset larger than set
        send_req(REQ_RESTART, '0, '0);
        send_req(REQ_ADVANCE, '0, '0);
        set_config(CFG_W'(16), CFG_W'(16));
        send_req(REQ_RESTART, '0, '0);
        send_req(REQ_ADVANCE, '0, '0);
    endtask

    task automatic test_output_stall();
        set_config(CFG_W'(7), CFG_W'(3));
        sink_hold = 1'b1;
        send_req(REQ_RESTART, '0, '0);
        repeat (6) send_req(REQ_ADVANCE, '0, '0);
        wait_drain();
        // sender idles until all results are back, then resumes
        repeat (4) send_req(REQ_ADVANCE, '0, '0);
    endtask

    task automatic test_random();
        int phase, roll, burst, n, k;
        phase = 0;
        while (item_cnt < ITEM_TARGET) begin
            case ($urandom_range(9))
                0: begin
                    n = $urandom_range(16, 64);
                    k = $urandom_range(1, 16);
                end
                1: begin
                    n = $urandom_range(1, 15);
                    k = $urandom_range(n + 1, 16);
                end
                default: begin
                    n = $urandom_range(2, 10);
                    k = $urandom_range(1, n);
                end
            endcase
            set_config(CFG_W'(n), CFG_W'(k));
            src_idle_en  = (phase != 1);
            sink_idle_en = (phase != 1);
            burst = $urandom_range(30, 50);
            repeat (burst) begin
                roll = $urandom_range(99);
                if (roll < 5)
                    send_req(REQ_RESERVED, POS_W'($urandom), VAL_W'($urandom));
                else if (roll < 18)
                    send_req(REQ_WRITE, POS_W'($urandom), VAL_W'($urandom));
                else if (roll < 28)
                    send_req(REQ_RESTART, POS_W'($urandom), VAL_W'($urandom));
                else if (roll < 36 && active_k() <= active_n()) begin
                    load_random_combination();
                    advance_or_restart();
                end else if (roll < 39) begin
                    wait_drain();
                    advance_or_restart();
                end else
                    advance_or_restart();
            end
            phase++;
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (sink_hold) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold = 1'b0;
            end
            out_ready <= !sink_idle_en || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            result_cnt++;
            if (pending_elems.size() == 0) begin
                error_cnt++;
                if (error_cnt <= MAX_REPORTS)
                    $display({"%0t: unexpected result, expected none, ",
                              "actual slot=%0d value=%0d found=%0b last=%0b"},
                             $time, elem_index, elem_value, found, last);
            end else begin
                head_elem = pending_elems.pop_front();
                if (head_elem.slot !== elem_index || head_elem.elem !== elem_value ||
                    head_elem.found !== found || head_elem.last !== last) begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS)
                        $display({"%0t: mismatch expected slot=%0d value=%0d found=%0b ",
                                  "last=%0b, actual slot=%0d value=%0d found=%0b last=%0b"},
                                 $time, head_elem.slot, head_elem.elem, head_elem.found,
                                 head_elem.last, elem_index, elem_value, found, last);
                end
            end
        end
    end

    // no transaction in either direction for too long means a hang
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, pending_elems.size());
            $display("Simulation FAILED");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_config_extremes();
        test_output_stall();
        test_random();

        wait_quiet();
        if (pending_elems.size() != 0) error_cnt++;

        $display({"Covered %0d requests and %0d result transactions (%0d exhausted) ",
                  "over %0d settings,"},
                 item_cnt, result_cnt, exhaust_cnt, setting_cnt);
        $display({"including saturated sizes, subset above set, a long output stall ",
                  "and idle-free bursts."});
        if (error_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
